// File: rtl/x2l_pkg.sv
// Shared constants and types for the XYZ to Lab converter.
package x2l_pkg;

	localparam int TRI_W  = 16;
	localparam int RCP_W  = 16;
	localparam int OUT_W  = 18;
	localparam int P_W    = 33;
	localparam int PROD_W = 57;
	localparam int F_W    = 28;
	localparam int ACC_W  = 40;
	localparam int ROOT_W = 21;
	localparam int SQ_W   = 42;
	localparam int REM_W  = 48;
	localparam int RAD_W  = 63;
	localparam int CBRT_STEPS = 21;

	localparam logic signed [P_W-1:0]    LIN_LIMIT  = 33'sd2377264;
	localparam logic signed [24:0]       LIN_SLOPE  = 25'sd8165261;
	localparam logic signed [PROD_W-1:0] LIN_HALF   = 57'sd134217728;
	localparam logic signed [F_W-1:0]    LIN_OFFSET = 28'sd144631;
	localparam logic signed [ACC_W-1:0]  L_OFFSET   = 40'sd16777216;
	localparam logic signed [ACC_W-1:0]  OUT_HALF   = 40'sd4096;
	localparam logic signed [OUT_W-1:0]  OUT_MAX    = 18'sd131071;
	localparam logic signed [OUT_W-1:0]  OUT_MIN    = -18'sd131072;

	localparam logic [1:0] CFG_WHITE_X = 2'd0;
	localparam logic [1:0] CFG_WHITE_Y = 2'd1;
	localparam logic [1:0] CFG_WHITE_Z = 2'd2;

	localparam logic [RCP_W-1:0] WHITE_X_RST = 16'd17238;
	localparam logic [RCP_W-1:0] WHITE_Y_RST = 16'd16384;
	localparam logic [RCP_W-1:0] WHITE_Z_RST = 16'd15047;

	typedef struct packed {
		logic [REM_W-1:0]       rem;
		logic [ROOT_W-1:0]      root;
		logic [SQ_W-1:0]        root_sq;
		logic [RAD_W-1:0]       radicand;
		logic                   use_cbrt;
		logic signed [F_W-1:0]  lin;
	} cbrt_t;

endpackage

// File: rtl/x2l_cbrt_step.sv
// One registered bit step of the restoring integer cube root.
module x2l_cbrt_step (
	input  logic             clk,
	input  logic             en,
	input  x2l_pkg::cbrt_t   d,
	output x2l_pkg::cbrt_t   q
);

	logic [x2l_pkg::ROOT_W-1:0] root2;
	logic [x2l_pkg::SQ_W-1:0]   sq2;
	logic [x2l_pkg::REM_W-1:0]  sum;
	logic [x2l_pkg::REM_W-1:0]  trial;
	logic [x2l_pkg::REM_W-1:0]  rem2;
	x2l_pkg::cbrt_t             nxt;

	always_comb begin
		root2 = {d.root[x2l_pkg::ROOT_W-2:0], 1'b0};
		sq2   = {d.root_sq[x2l_pkg::SQ_W-3:0], 2'b00};
		sum   = x2l_pkg::REM_W'(sq2) + x2l_pkg::REM_W'(root2);
		trial = {sum[x2l_pkg::REM_W-2:0], 1'b0} + sum + x2l_pkg::REM_W'(1);
		rem2  = {d.rem[x2l_pkg::REM_W-4:0], d.radicand[x2l_pkg::RAD_W-1 -: 3]};
		nxt          = d;
		nxt.radicand = {d.radicand[x2l_pkg::RAD_W-4:0], 3'b000};
		if (rem2 >= trial) begin
			nxt.rem     = rem2 - trial;
			nxt.root    = root2 + x2l_pkg::ROOT_W'(1);
			nxt.root_sq = sq2 + x2l_pkg::SQ_W'({root2, 1'b0}) + x2l_pkg::SQ_W'(1);
		end else begin
			nxt.rem     = rem2;
			nxt.root    = root2;
			nxt.root_sq = sq2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// File: rtl/x2l_lane.sv
// One channel: white scaling, linear branch and pipelined cube root, giving f(t) in Q.20.
module x2l_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [x2l_pkg::TRI_W-1:0]  tri_val,
	input  logic        [x2l_pkg::RCP_W-1:0]  recip,
	output logic signed [x2l_pkg::F_W-1:0]    f_val
);

	logic signed [x2l_pkg::P_W-1:0]    p_s1;
	logic signed [x2l_pkg::PROD_W-1:0] prod_s2;
	x2l_pkg::cbrt_t                    st_s2;
	x2l_pkg::cbrt_t                    chain [0:x2l_pkg::CBRT_STEPS];
	logic signed [x2l_pkg::PROD_W-1:0] lin_rnd;
	logic                              sel;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= x2l_pkg::P_W'($signed({{1{tri_val[x2l_pkg::TRI_W-1]}}, tri_val})
				* $signed({1'b0, recip}));
		end
	end

	assign sel = (p_s1 > x2l_pkg::LIN_LIMIT);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2          <= x2l_pkg::PROD_W'(p_s1 * x2l_pkg::LIN_SLOPE);
			st_s2.rem        <= '0;
			st_s2.root       <= '0;
			st_s2.root_sq    <= '0;
			st_s2.radicand   <= sel ? {p_s1[30:0], 32'd0} : '0;
			st_s2.use_cbrt   <= sel;
			st_s2.lin        <= '0;
		end
	end

	always_comb begin
		lin_rnd      = (prod_s2 + x2l_pkg::LIN_HALF) >>> 28;
		chain[0]     = st_s2;
		chain[0].lin = x2l_pkg::F_W'(lin_rnd) + x2l_pkg::LIN_OFFSET;
	end

	for (genvar i = 0; i < x2l_pkg::CBRT_STEPS; i++) begin : g_step
		x2l_cbrt_step u_step (
			.clk (clk),
			.en  (en),
			.d   (chain[i]),
			.q   (chain[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_val <= chain[x2l_pkg::CBRT_STEPS].use_cbrt
				? $signed(x2l_pkg::F_W'(chain[x2l_pkg::CBRT_STEPS].root))
				: chain[x2l_pkg::CBRT_STEPS].lin;
		end
	end

endmodule

// File: rtl/xyz_to_lab_convert.sv
// Top level of the CIE XYZ to CIE L*a*b* pixel converter.
// Usage:
//   Input channel (in_valid/in_ready) takes one pixel per transaction: X, Y, Z in
//   signed Q2.14. Output channel (out_valid/out_ready) gives L*, a*, b* in signed
//   Q11.7, rounded to nearest and saturated.
//   Config channel (cfg_valid/cfg_ready, always ready) writes the white reciprocals,
//   unsigned Q2.14: index 0 X, 1 Y, 2 Z; index 3 is ignored. Write only while idle.
//   Throughput is one pixel per cycle while the receiver does not stall. The
//   pipeline is made of the 21 one-bit stages of the cube root plus the
//   scaling multiply, linear-branch multiply, branch select, output mix and rounding
//   stages.
//   The whole pipeline advances together: when the receiver stalls with a result
//   waiting, in_ready drops and every stage holds; no transaction is lost or
//   repeated. Bubbles travel with their valid bits.
//   Reset clears all valid bits and loads the D65 white reciprocals.
//   No internal state carries from one pixel to the next.
module xyz_to_lab_convert (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         cfg_index,
	input  logic [x2l_pkg::RCP_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [x2l_pkg::TRI_W-1:0]   x_tristimulus,
	input  logic signed [x2l_pkg::TRI_W-1:0]   y_tristimulus,
	input  logic signed [x2l_pkg::TRI_W-1:0]   z_tristimulus,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [x2l_pkg::OUT_W-1:0]   lightness,
	output logic signed [x2l_pkg::OUT_W-1:0]   green_red,
	output logic signed [x2l_pkg::OUT_W-1:0]   blue_yellow
);

	localparam int DEPTH = 26;

	logic [x2l_pkg::RCP_W-1:0]        wx_q, wy_q, wz_q;
	logic [DEPTH-1:0]                 vld_q;
	logic                             en;
	logic signed [x2l_pkg::F_W-1:0]   fx, fy, fz;
	logic signed [x2l_pkg::ACC_W-1:0] l_s25, a_s25, b_s25;
	logic signed [x2l_pkg::OUT_W-1:0] l_s26, a_s26, b_s26;

	assign cfg_ready = 1'b1;
	assign en        = !vld_q[DEPTH-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wx_q <= x2l_pkg::WHITE_X_RST;
			wy_q <= x2l_pkg::WHITE_Y_RST;
			wz_q <= x2l_pkg::WHITE_Z_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				x2l_pkg::CFG_WHITE_X: wx_q <= cfg_data;
				x2l_pkg::CFG_WHITE_Y: wy_q <= cfg_data;
				x2l_pkg::CFG_WHITE_Z: wz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	x2l_lane u_lane_x (.clk(clk), .en(en), .tri_val(x_tristimulus), .recip(wx_q), .f_val(fx));
	x2l_lane u_lane_y (.clk(clk), .en(en), .tri_val(y_tristimulus), .recip(wy_q), .f_val(fy));
	x2l_lane u_lane_z (.clk(clk), .en(en), .tri_val(z_tristimulus), .recip(wz_q), .f_val(fz));

	always_ff @(posedge clk) begin
		if (en) begin
			l_s25 <= x2l_pkg::ACC_W'(fy) * 40'sd116 - x2l_pkg::L_OFFSET;
			a_s25 <= (x2l_pkg::ACC_W'(fx) - x2l_pkg::ACC_W'(fy)) * 40'sd500;
			b_s25 <= (x2l_pkg::ACC_W'(fy) - x2l_pkg::ACC_W'(fz)) * 40'sd200;
		end
	end

	function automatic logic signed [x2l_pkg::OUT_W-1:0] rnd_sat(
		input logic signed [x2l_pkg::ACC_W-1:0] v
	);
		logic signed [x2l_pkg::ACC_W-1:0] r;
		r = (v + x2l_pkg::OUT_HALF) >>> 13;
		if (r > x2l_pkg::ACC_W'(x2l_pkg::OUT_MAX)) begin
			return x2l_pkg::OUT_MAX;
		end else if (r < x2l_pkg::ACC_W'(x2l_pkg::OUT_MIN)) begin
			return x2l_pkg::OUT_MIN;
		end
		return x2l_pkg::OUT_W'(r);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			l_s26 <= rnd_sat(l_s25);
			a_s26 <= rnd_sat(a_s25);
			b_s26 <= rnd_sat(b_s25);
		end
	end

	assign lightness   = l_s26;
	assign green_red   = a_s26;
	assign blue_yellow = b_s26;

endmodule
